[rtl/core/alu_with_condition_flags_macros.svh]
// Assertion macros shared by the ALU RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ALU_WITH_CONDITION_FLAGS_MACROS_SVH
`define ALU_WITH_CONDITION_FLAGS_MACROS_SVH

// Check on every rising edge outside reset.
`define AWCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define AWCF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/alu_wcf_pkg.sv]
// Shared types and constants of the condition-flag ALU.
// No dependencies.
package alu_wcf_pkg;

  localparam int unsigned DefaultWordWidth = 32;
  localparam int unsigned FieldWidth       = 32;
  localparam int unsigned KindWidth        = 4;
  localparam int unsigned ShAmtWidth       = 5;

  typedef enum logic [KindWidth-1:0] {
    OpAdd = 4'd0,
    OpAdc = 4'd1,
    OpSub = 4'd2,
    OpSbc = 4'd3,
    OpAnd = 4'd4,
    OpOr  = 4'd5,
    OpXor = 4'd6,
    OpNot = 4'd7,
    OpSrl = 4'd8,
    OpSll = 4'd9,
    OpSra = 4'd10,
    OpSla = 4'd11,
    OpRr  = 4'd12,
    OpRl  = 4'd13
  } op_e;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

endpackage

[rtl/core/alu_with_condition_flags.sv]
// Top level of the ALU with stored N, Z, V and C flags: input register,
// datapath, result register and flag register. Depends on alu_wcf_pkg,
// alu_wcf_alu and the assertion macros header.
//
//   channel  | dir | tdata                         | tuser
//   ---------+-----+-------------------------------+-----------------------------
//   s_axis   | in  | [31:0] operand_a [63:32] opnd_b | [3:0] kind
//   m_axis   | out | [31:0] result                 | [0] n [1] z [2] v [3] c
//
// One word per cycle sustained while the result is taken; an accepted word
// passes through the input register and then the result register. The flags
// register updates when a word moves from the
// input register to the result register, so adc and sbc see the carry of the
// word just before them with no bubble.
// Reset clears the valid bits and the stored flags. A stalled result holds the
// result register and the input register; a new word is still taken while
// the input register is empty or moves on in the same cycle.
`include "alu_with_condition_flags_macros.svh"

module alu_with_condition_flags #(
  parameter int unsigned WordWidth = alu_wcf_pkg::DefaultWordWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] operand_a, [63:32] operand_b
  input  logic [3:0]  s_axis_tuser_i,   // [3:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result
  output logic [3:0]  m_axis_tuser_o    // [0] flag_n, [1] flag_z, [2] flag_v, [3] flag_c
);

  localparam int unsigned FW = alu_wcf_pkg::FieldWidth;

  // Input register.
  logic                 in_valid_q;
  alu_wcf_pkg::op_e     op_q;
  logic [FW-1:0]        a_q;
  logic [FW-1:0]        b_q;

  // Result register and stored flags.
  logic                 out_valid_q;
  logic [FW-1:0]        result_q;
  logic [FW-1:0]        result_d;
  alu_wcf_pkg::flags_t  out_flags_q;
  alu_wcf_pkg::flags_t  flags_q;
  alu_wcf_pkg::flags_t  flags_d;

  logic                 advance;
  logic                 in_ready;

  // Move a word to the result register when that register is free or drains now.
  assign advance  = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign in_ready = !in_valid_q || advance;

  assign s_axis_tready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      op_q <= alu_wcf_pkg::op_e'(s_axis_tuser_i);
      a_q  <= s_axis_tdata_i[FW-1:0];
      b_q  <= s_axis_tdata_i[2*FW-1:FW];
    end
  end

  alu_wcf_alu #(
    .WordWidth(WordWidth)
  ) u_alu (
    .op_i    (op_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .flags_i (flags_q),
    .result_o(result_d),
    .flags_o (flags_d)
  );

  // Valid and flags need reset; the result payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q    <= result_d;
      out_flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = result_q;
  assign m_axis_tuser_o  = {out_flags_q.c, out_flags_q.v, out_flags_q.z, out_flags_q.n};

  `AWCF_ASSERT(a_flags_hold, !advance |=> $stable(flags_q), "flags changed without a word")
  `AWCF_ASSERT(a_out_flags_match, out_valid_q |-> (out_flags_q == flags_q),
               "shown flags differ from stored flags")
  `AWCF_ASSERT(a_no_overrun, (in_valid_q && !advance) |-> !s_axis_tready_o,
               "input register overrun")
  `AWCF_ASSERT_RST(a_reset_clear, !rst_ni |-> (!out_valid_q && !in_valid_q && (flags_q == '0)),
                   "reset did not clear control state")

endmodule

[rtl/core/alu_wcf_shift.sv]
// Shift and rotate unit of the condition-flag ALU.
// Depends on alu_wcf_pkg.
module alu_wcf_shift #(
  parameter int unsigned WordWidth = alu_wcf_pkg::DefaultWordWidth
) (
  input  alu_wcf_pkg::op_e                  op_i,
  input  logic [WordWidth-1:0]              a_i,
  input  logic [alu_wcf_pkg::ShAmtWidth-1:0] sh_i,
  output logic [WordWidth-1:0]              result_o
);

  localparam int unsigned ShW      = alu_wcf_pkg::ShAmtWidth;
  // Subtractions needed to bring the largest amount below the word width.
  localparam int unsigned RotSteps = ((1 << ShW) - 1) / WordWidth;

  logic [ShW-1:0]         rot_amt;
  logic [2*WordWidth-1:0] rot_r;
  logic [2*WordWidth-1:0] rot_l;

  // Reduce the rotate amount modulo the word width.
  always_comb begin
    rot_amt = sh_i;
    for (int i = 0; i < RotSteps; i++) begin
      if (32'(rot_amt) >= WordWidth) begin
        rot_amt = rot_amt - ShW'(WordWidth);
      end
    end
  end

  assign rot_r = {a_i, a_i} >> rot_amt;
  assign rot_l = {a_i, a_i} << rot_amt;

  // Shifts by the word width or more give zero or sign fill, as the operators do.
  always_comb begin
    case (op_i)
      alu_wcf_pkg::OpSrl: result_o = a_i >> sh_i;
      alu_wcf_pkg::OpSll,
      alu_wcf_pkg::OpSla: result_o = a_i << sh_i;
      alu_wcf_pkg::OpSra: result_o = WordWidth'($signed(a_i) >>> sh_i);
      alu_wcf_pkg::OpRr:  result_o = rot_r[WordWidth-1:0];
      alu_wcf_pkg::OpRl:  result_o = rot_l[2*WordWidth-1:WordWidth];
      default:            result_o = '0;
    endcase
  end

endmodule

[rtl/core/alu_wcf_alu.sv]
// Combinational datapath: arithmetic, logic, shifter and flag update.
// Depends on alu_wcf_pkg and alu_wcf_shift.
module alu_wcf_alu #(
  parameter int unsigned WordWidth = alu_wcf_pkg::DefaultWordWidth
) (
  input  alu_wcf_pkg::op_e                    op_i,
  input  logic [alu_wcf_pkg::FieldWidth-1:0]  a_i,
  input  logic [alu_wcf_pkg::FieldWidth-1:0]  b_i,
  input  alu_wcf_pkg::flags_t                 flags_i,
  output logic [alu_wcf_pkg::FieldWidth-1:0]  result_o,
  output alu_wcf_pkg::flags_t                 flags_o
);

  localparam int unsigned FW = alu_wcf_pkg::FieldWidth;

  logic [WordWidth-1:0] a_w;
  logic [WordWidth-1:0] b_w;
  logic [WordWidth-1:0] shift_res;
  logic [WordWidth-1:0] res_w;
  logic [WordWidth:0]   sum;
  logic [WordWidth:0]   diff;
  logic [WordWidth:0]   cin_ext;
  logic                 cin;
  logic                 arith;
  logic                 known;

  // Fit the 32-bit fields to the word width.
  if (WordWidth <= FW) begin : g_narrow
    assign a_w = a_i[WordWidth-1:0];
    assign b_w = b_i[WordWidth-1:0];
  end else begin : g_wide
    assign a_w = {{(WordWidth-FW){1'b0}}, a_i};
    assign b_w = {{(WordWidth-FW){1'b0}}, b_i};
  end

  if (WordWidth >= FW) begin : g_res_cut
    assign result_o = res_w[FW-1:0];
  end else begin : g_res_ext
    assign result_o = {{(FW-WordWidth){1'b0}}, res_w};
  end

  assign cin     = ((op_i == alu_wcf_pkg::OpAdc) || (op_i == alu_wcf_pkg::OpSbc)) && flags_i.c;
  assign cin_ext = {{WordWidth{1'b0}}, cin};
  assign sum     = {1'b0, a_w} + {1'b0, b_w} + cin_ext;
  // Top bit is the borrow out of a - b - cin.
  assign diff    = {1'b0, a_w} - {1'b0, b_w} - cin_ext;

  alu_wcf_shift #(
    .WordWidth(WordWidth)
  ) u_shift (
    .op_i    (op_i),
    .a_i     (a_w),
    .sh_i    (b_i[alu_wcf_pkg::ShAmtWidth-1:0]),
    .result_o(shift_res)
  );

  always_comb begin
    arith = 1'b0;
    known = 1'b1;
    case (op_i)
      alu_wcf_pkg::OpAdd,
      alu_wcf_pkg::OpAdc: begin
        res_w = sum[WordWidth-1:0];
        arith = 1'b1;
      end
      alu_wcf_pkg::OpSub,
      alu_wcf_pkg::OpSbc: begin
        res_w = diff[WordWidth-1:0];
        arith = 1'b1;
      end
      alu_wcf_pkg::OpAnd: res_w = a_w & b_w;
      alu_wcf_pkg::OpOr:  res_w = a_w | b_w;
      alu_wcf_pkg::OpXor: res_w = a_w ^ b_w;
      alu_wcf_pkg::OpNot: res_w = ~a_w;
      alu_wcf_pkg::OpSrl,
      alu_wcf_pkg::OpSll,
      alu_wcf_pkg::OpSra,
      alu_wcf_pkg::OpSla,
      alu_wcf_pkg::OpRr,
      alu_wcf_pkg::OpRl:  res_w = shift_res;
      default: begin
        res_w = '0;
        known = 1'b0;
      end
    endcase
  end

  // Unused codes keep every flag; logic and shifts keep V and C.
  always_comb begin
    flags_o = flags_i;
    if (known) begin
      flags_o.n = res_w[WordWidth-1];
      flags_o.z = (res_w == '0);
      if (arith) begin
        if ((op_i == alu_wcf_pkg::OpAdd) || (op_i == alu_wcf_pkg::OpAdc)) begin
          flags_o.c = sum[WordWidth];
          flags_o.v = (a_w[WordWidth-1] ^ res_w[WordWidth-1]) &
                      (b_w[WordWidth-1] ^ res_w[WordWidth-1]);
        end else begin
          flags_o.c = diff[WordWidth];
          flags_o.v = (a_w[WordWidth-1] ^ b_w[WordWidth-1]) &
                      (a_w[WordWidth-1] ^ res_w[WordWidth-1]);
        end
      end
    end
  end

endmodule
